### sv/fht_pkg.sv
// Shared types and constants for the floor heating thermostat.
// Used by every module of the block; depends on nothing.
`default_nettype none

package fht_pkg;

    // Field widths fixed by the register map and result format.
    localparam int SP_W        = 8;
    localparam int HOLD_CFG_W  = 20;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 20;

    // Default parameter values.
    localparam int DEF_TEMP_WIDTH = 16;
    localparam int DEF_HOLD_WIDTH = 20;

    // Register reset values.
    localparam logic [SP_W-1:0]       RST_USER_SP    = 8'd0;
    localparam logic [SP_W-1:0]       RST_NIGHT_RED  = 8'd2;
    localparam logic [SP_W-1:0]       RST_SP_MIN     = 8'd6;
    localparam logic [SP_W-1:0]       RST_SP_MAX     = 8'd33;
    localparam logic [SP_W-1:0]       RST_ROOM_HYST  = 8'd8;
    localparam logic [SP_W-1:0]       RST_FLOOR_HYST = 8'd8;
    localparam logic [HOLD_CFG_W-1:0] RST_MIN_HOLD   = 20'd300000;

    // Register indexes on the configuration port.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_USER_SETPOINT    = 3'd0,
        CFG_NIGHT_REDUCTION  = 3'd1,
        CFG_SETPOINT_MIN     = 3'd2,
        CFG_SETPOINT_MAX     = 3'd3,
        CFG_ROOM_HYSTERESIS  = 3'd4,
        CFG_FLOOR_HYSTERESIS = 3'd5,
        CFG_MIN_HOLD_TICKS   = 3'd6
    } cfg_index_t;

    // Current register contents.
    typedef struct packed {
        logic [SP_W-1:0]       user_setpoint;
        logic [SP_W-1:0]       night_reduction;
        logic [SP_W-1:0]       setpoint_min;
        logic [SP_W-1:0]       setpoint_max;
        logic [SP_W-1:0]       room_hysteresis;
        logic [SP_W-1:0]       floor_hysteresis;
        logic [HOLD_CFG_W-1:0] min_hold_ticks;
    } cfg_t;

    // Mode flags of one input word.
    typedef struct packed {
        logic day_mode;
        logic window1_closed;
        logic window2_closed;
        logic heating_enabled;
        logic time_tick;
    } mode_t;

    // One result word.
    typedef struct packed {
        logic [SP_W-1:0] internal_setpoint;
        logic            heat_demand;
        logic            relay_command;
        logic            relay_update;
        logic            floor_over_limit;
    } result_t;

endpackage

`default_nettype wire

### sv/fht_setpoint.sv
// Working setpoint selection: frost, day or night setpoint, then clamping.
// Depends on fht_pkg.
`default_nettype none

module fht_setpoint (
    input  fht_pkg::cfg_t              cfg,
    input  fht_pkg::mode_t             mode,
    output logic [fht_pkg::SP_W-1:0]   setpoint
);
    import fht_pkg::*;

    logic signed [SP_W+1:0] raw;
    logic signed [SP_W+1:0] upper;
    logic signed [SP_W+1:0] clamped;
    logic signed [SP_W+1:0] sp_min;
    logic signed [SP_W+1:0] sp_max;

    always_comb
    begin
        sp_min = $signed({2'b00, cfg.setpoint_min});
        sp_max = $signed({2'b00, cfg.setpoint_max});
        if (!mode.heating_enabled || !mode.window1_closed || !mode.window2_closed)
        begin
            raw = sp_min;
        end
        else if (!mode.day_mode)
        begin
            // Signed subtraction; a negative result is lifted by the lower clamp.
            raw = $signed({2'b00, cfg.user_setpoint}) - $signed({2'b00, cfg.night_reduction});
        end
        else
        begin
            raw = $signed({2'b00, cfg.user_setpoint});
        end
        // Upper clamp first, so inverted limits resolve to the minimum.
        upper   = (raw > sp_max) ? sp_max : raw;
        clamped = (upper < sp_min) ? sp_min : upper;
    end

    assign setpoint = clamped[SP_W-1:0];

endmodule

`default_nettype wire

### sv/fht_regulator.sv
// Room two-point regulator, floor over-limit latch and relay hold timer.
// Holds the regulator state; depends on fht_pkg.
`default_nettype none

module fht_regulator #(
    parameter int TEMP_WIDTH = fht_pkg::DEF_TEMP_WIDTH,
    parameter int HOLD_WIDTH = fht_pkg::DEF_HOLD_WIDTH
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             step,
    input  fht_pkg::cfg_t                    cfg,
    input  logic signed [TEMP_WIDTH-1:0]     room_temp,
    input  logic signed [TEMP_WIDTH-1:0]     floor_temp,
    input  logic                             time_tick,
    input  logic [fht_pkg::SP_W-1:0]         setpoint,
    output fht_pkg::result_t                 result
);
    import fht_pkg::*;

    localparam int CMP_W = TEMP_WIDTH + 2;
    localparam int HC_W  = (HOLD_WIDTH > HOLD_CFG_W) ? HOLD_WIDTH : HOLD_CFG_W;
    localparam logic [HOLD_WIDTH-1:0] HOLD_MAX = {HOLD_WIDTH{1'b1}};

    logic                  demand_reg,    demand_next;
    logic                  latch_reg,     latch_next;
    logic                  committed_reg, committed_next;
    logic [HOLD_WIDTH-1:0] hold_reg,      hold_next;

    logic signed [CMP_W-1:0] room_x;
    logic signed [CMP_W-1:0] floor_x;
    logic signed [CMP_W-1:0] room_ref;
    logic signed [CMP_W-1:0] room_low;
    logic signed [CMP_W-1:0] floor_ref;
    logic signed [CMP_W-1:0] floor_low;
    logic                    room_demand;
    logic [HOLD_WIDTH-1:0]   hold_inc;
    logic                    commit;

    always_comb
    begin
        room_x    = $signed({{2{room_temp[TEMP_WIDTH-1]}}, room_temp});
        floor_x   = $signed({{2{floor_temp[TEMP_WIDTH-1]}}, floor_temp});
        room_ref  = $signed({{(CMP_W-SP_W-4){1'b0}}, setpoint, 4'b0000});
        room_low  = room_ref - $signed({{(CMP_W-SP_W){1'b0}}, cfg.room_hysteresis});
        floor_ref = $signed({{(CMP_W-SP_W-4){1'b0}}, cfg.setpoint_max, 4'b0000});
        floor_low = floor_ref - $signed({{(CMP_W-SP_W){1'b0}}, cfg.floor_hysteresis});

        if (room_x > room_ref)
        begin
            room_demand = 1'b0;
        end
        else if (room_x <= room_low)
        begin
            room_demand = 1'b1;
        end
        else
        begin
            room_demand = demand_reg;
        end

        if (floor_x >= floor_ref)
        begin
            latch_next = 1'b1;
        end
        else if (floor_x < floor_low)
        begin
            latch_next = 1'b0;
        end
        else
        begin
            latch_next = latch_reg;
        end

        demand_next = room_demand && !latch_next;

        // The counter saturates; the commit test sees the incremented value.
        hold_inc = (time_tick && (hold_reg != HOLD_MAX)) ? hold_reg + 1'b1 : hold_reg;
        commit   = (committed_reg != demand_next)
                   && (HC_W'(hold_inc) > HC_W'(cfg.min_hold_ticks));

        committed_next = commit ? demand_next : committed_reg;
        hold_next      = commit ? '0 : hold_inc;

        result.internal_setpoint = setpoint;
        result.heat_demand       = demand_next;
        result.relay_command     = committed_next;
        result.relay_update      = commit;
        result.floor_over_limit  = latch_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            demand_reg    <= 1'b0;
            latch_reg     <= 1'b0;
            committed_reg <= 1'b1;
            hold_reg      <= '0;
        end
        else if (step)
        begin
            demand_reg    <= demand_next;
            latch_reg     <= latch_next;
            committed_reg <= committed_next;
            hold_reg      <= hold_next;
        end
    end

endmodule

`default_nettype wire

### sv/floor_heating_thermostat_top.sv
// Top level of the floor heating thermostat: input register, configuration
// registers, result register. Depends on fht_pkg, fht_setpoint, fht_regulator.
`default_nettype none

// The thermostat takes one word per cycle while in_stall is low and returns one
// result word per input word, passed from the input register to the result register.
// A word is first captured in an input register; when the stage advances, the setpoint
// selection, the room and floor comparisons and the relay hold timer update all
// the state at once and the result is written to the output register. Both
// registers run back to back, so the sustained rate is one word per clock while out_stall
// is low, and a new word is still accepted while a finished result waits on out_stall.
// The configuration port is always ready. Registers should be written only
// while no word is in flight, as the regulator reads them directly.
// Temperatures are signed in sixteenths of a degree; setpoints are whole
// degrees. The relay hold counter is HOLD_WIDTH bits wide and saturates.
module floor_heating_thermostat_top #(
    parameter int TEMP_WIDTH = fht_pkg::DEF_TEMP_WIDTH,
    parameter int HOLD_WIDTH = fht_pkg::DEF_HOLD_WIDTH
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // Configuration write channel.
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [fht_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [fht_pkg::CFG_DATA_W-1:0]       cfg_data,
    // Input channel.
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic signed [TEMP_WIDTH-1:0]         room_temp,
    input  logic signed [TEMP_WIDTH-1:0]         floor_temp,
    input  logic                                 day_mode,
    input  logic                                 window1_closed,
    input  logic                                 window2_closed,
    input  logic                                 heating_enabled,
    input  logic                                 time_tick,
    // Output channel.
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [fht_pkg::SP_W-1:0]             internal_setpoint,
    output logic                                 heat_demand,
    output logic                                 relay_command,
    output logic                                 relay_update,
    output logic                                 floor_over_limit
);
    import fht_pkg::*;

    cfg_t cfg_reg;

    // Input register.
    logic                          in_valid_reg;
    logic signed [TEMP_WIDTH-1:0]  room_reg;
    logic signed [TEMP_WIDTH-1:0]  floor_reg;
    mode_t                         mode_reg;

    // Result register.
    logic                          out_valid_reg;
    result_t                       result_reg;

    logic                          take_in;
    logic                          advance;
    logic [SP_W-1:0]               setpoint;
    result_t                       result;

    // The stage advances when the output register is empty or being drained.
    assign advance   = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = in_valid_reg && !advance;
    assign take_in   = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.user_setpoint    <= RST_USER_SP;
            cfg_reg.night_reduction  <= RST_NIGHT_RED;
            cfg_reg.setpoint_min     <= RST_SP_MIN;
            cfg_reg.setpoint_max     <= RST_SP_MAX;
            cfg_reg.room_hysteresis  <= RST_ROOM_HYST;
            cfg_reg.floor_hysteresis <= RST_FLOOR_HYST;
            cfg_reg.min_hold_ticks   <= RST_MIN_HOLD;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_USER_SETPOINT:    cfg_reg.user_setpoint    <= cfg_data[SP_W-1:0];
                CFG_NIGHT_REDUCTION:  cfg_reg.night_reduction  <= cfg_data[SP_W-1:0];
                CFG_SETPOINT_MIN:     cfg_reg.setpoint_min     <= cfg_data[SP_W-1:0];
                CFG_SETPOINT_MAX:     cfg_reg.setpoint_max     <= cfg_data[SP_W-1:0];
                CFG_ROOM_HYSTERESIS:  cfg_reg.room_hysteresis  <= cfg_data[SP_W-1:0];
                CFG_FLOOR_HYSTERESIS: cfg_reg.floor_hysteresis <= cfg_data[SP_W-1:0];
                CFG_MIN_HOLD_TICKS:   cfg_reg.min_hold_ticks   <= cfg_data[HOLD_CFG_W-1:0];
                default:              ;
            endcase
        end
    end

    // Valid flags of both registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take_in)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            room_reg                 <= room_temp;
            floor_reg                <= floor_temp;
            mode_reg.day_mode        <= day_mode;
            mode_reg.window1_closed  <= window1_closed;
            mode_reg.window2_closed  <= window2_closed;
            mode_reg.heating_enabled <= heating_enabled;
            mode_reg.time_tick       <= time_tick;
        end
        if (advance)
        begin
            result_reg <= result;
        end
    end

    fht_setpoint u_setpoint (
        .cfg      (cfg_reg),
        .mode     (mode_reg),
        .setpoint (setpoint)
    );

    fht_regulator #(
        .TEMP_WIDTH (TEMP_WIDTH),
        .HOLD_WIDTH (HOLD_WIDTH)
    ) u_regulator (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (advance),
        .cfg        (cfg_reg),
        .room_temp  (room_reg),
        .floor_temp (floor_reg),
        .time_tick  (mode_reg.time_tick),
        .setpoint   (setpoint),
        .result     (result)
    );

    assign out_valid         = out_valid_reg;
    assign internal_setpoint = result_reg.internal_setpoint;
    assign heat_demand       = result_reg.heat_demand;
    assign relay_command     = result_reg.relay_command;
    assign relay_update      = result_reg.relay_update;
    assign floor_over_limit  = result_reg.floor_over_limit;

endmodule

`default_nettype wire

### sv/fht_checker.sv
// Port-level checks for the floor heating thermostat, bound to the top level.
// Depends on fht_pkg and floor_heating_thermostat_top.
`default_nettype none

module fht_checker #(
    parameter int TEMP_WIDTH = fht_pkg::DEF_TEMP_WIDTH,
    parameter int HOLD_WIDTH = fht_pkg::DEF_HOLD_WIDTH
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    input  logic                                 cfg_ready,
    input  logic [fht_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [fht_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic                                 in_valid,
    input  logic                                 in_stall,
    input  logic signed [TEMP_WIDTH-1:0]         room_temp,
    input  logic signed [TEMP_WIDTH-1:0]         floor_temp,
    input  logic                                 day_mode,
    input  logic                                 window1_closed,
    input  logic                                 window2_closed,
    input  logic                                 heating_enabled,
    input  logic                                 time_tick,
    input  logic                                 out_valid,
    input  logic                                 out_stall,
    input  logic [fht_pkg::SP_W-1:0]             internal_setpoint,
    input  logic                                 heat_demand,
    input  logic                                 relay_command,
    input  logic                                 relay_update,
    input  logic                                 floor_over_limit
);
    import fht_pkg::*;

    localparam int HOLD_BITS = HOLD_WIDTH;

    // A stalled result word stays valid.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
    else $error("result word dropped while stalled");

    // A stalled result word does not change.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(internal_setpoint) && $stable(heat_demand)
            && $stable(relay_command) && $stable(relay_update) && $stable(floor_over_limit))
    else $error("stalled result word changed");

    // The floor latch always overrides the heat demand.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && floor_over_limit |-> !heat_demand)
    else $error("heat demand while floor over limit");

    // A relay change always commits the current demand.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && relay_update |-> relay_command == heat_demand && HOLD_BITS > 0)
    else $error("relay update does not follow demand");

endmodule

bind floor_heating_thermostat_top fht_checker #(
    .TEMP_WIDTH (TEMP_WIDTH),
    .HOLD_WIDTH (HOLD_WIDTH)
) u_fht_checker (.*);

`default_nettype wire
